@@ hdl/bdsl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdsl_pkg
// shared types and codes for the button debouncer with short and long press
// ----------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

   localparam int unsigned TS_W    = 32;  // millisecond timestamp width
   localparam int unsigned CFG_W   = 16;  // configuration register width
   localparam int unsigned CODE_W  = 2;   // edge and event code width
   localparam int unsigned CSR_IDX_W = 1; // two configuration registers

   // stable edge codes
   localparam logic [CODE_W-1:0] NO_EDGE      = 2'd0;
   localparam logic [CODE_W-1:0] EDGE_PRESS   = 2'd1;
   localparam logic [CODE_W-1:0] EDGE_RELEASE = 2'd2;

   // gesture event codes
   localparam logic [CODE_W-1:0] EV_NONE  = 2'd0;
   localparam logic [CODE_W-1:0] EV_SHORT = 2'd1;
   localparam logic [CODE_W-1:0] EV_LONG  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 1'b1;

   // configuration reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic            raw_level;
      logic [TS_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] edge_code;
      logic [CODE_W-1:0] press_event;
      logic              is_down;
      logic [TS_W-1:0]   hold_time_ms;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/bdsl_if.sv @@
// ----------------------------------------------------------------------------
// bdsl request and response channels
// valid/ready channels carrying pin samples and debounce results
// ----------------------------------------------------------------------------
`default_nettype none

interface bdsl_req_if;
   import bdsl_pkg::*;

   logic            valid;
   logic            ready;
   logic            raw_level;
   logic [TS_W-1:0] now_ms;

   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdsl_rsp_if;
   import bdsl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] edge_code;
   logic [CODE_W-1:0] press_event;
   logic              is_down;
   logic [TS_W-1:0]   hold_time_ms;

   modport source (output valid, output edge_code, output press_event,
                   output is_down, output hold_time_ms, input ready);
   modport sink   (input valid, input edge_code, input press_event,
                   input is_down, input hold_time_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/bdsl_core.sv @@
// ----------------------------------------------------------------------------
// bdsl_core
// debounce and press gesture state with its single-pass step logic
// ----------------------------------------------------------------------------
`default_nettype none

module bdsl_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire bdsl_pkg::req_type req,
   input  wire bdsl_pkg::cfg_type cfg,
   output bdsl_pkg::rsp_type      rsp
);
   import bdsl_pkg::*;

   logic            prev_raw_ff,         prev_raw_in;
   logic            stable_now_ff,       stable_now_in;
   logic            stable_before_ff,    stable_before_in;
   logic [TS_W-1:0] raw_change_stamp_ff, raw_change_stamp_in;
   logic            press_active_ff,     press_active_in;
   logic            long_reported_ff,    long_reported_in;
   logic [TS_W-1:0] press_stamp_ff,      press_stamp_in;
   logic [TS_W-1:0] last_hold_len_ff,    last_hold_len_in;

   logic            raw_changed;
   logic [TS_W-1:0] raw_age;
   logic            debounce_done;
   logic            press_edge;
   logic            release_edge;
   logic [TS_W-1:0] press_age_old;
   logic [TS_W-1:0] press_age;
   logic            short_fire;
   logic            long_fire;
   logic            long_clear;

   always_comb begin
      raw_changed         = req.raw_level != prev_raw_ff;
      prev_raw_in         = req.raw_level;
      raw_change_stamp_in = raw_changed ? req.now_ms : raw_change_stamp_ff;
      raw_age             = raw_changed ? '0 : req.now_ms - raw_change_stamp_ff;
      debounce_done       = (|raw_age[TS_W-1:CFG_W])
                          || (raw_age[CFG_W-1:0] >= cfg.debounce_ms);
      stable_now_in       = debounce_done ? req.raw_level : stable_now_ff;
      stable_before_in    = stable_now_in;

      press_edge   = (stable_now_in != stable_before_ff) && !stable_now_in;
      release_edge = (stable_now_in != stable_before_ff) && stable_now_in;

      // age of the current press, zero on the press step itself
      press_age_old  = req.now_ms - press_stamp_ff;
      press_age      = press_edge ? '0 : press_age_old;
      press_stamp_in = press_edge ? req.now_ms : press_stamp_ff;

      short_fire = release_edge && press_active_ff && !long_reported_ff
                && (~|press_age_old[TS_W-1:CFG_W])
                && (press_age_old[CFG_W-1:0] < cfg.long_press_ms);

      if (release_edge) begin
         last_hold_len_in = press_active_ff ? press_age_old : '0;
      end else begin
         last_hold_len_in = last_hold_len_ff;
      end

      if (press_edge) begin
         press_active_in = 1'b1;
      end else if (release_edge) begin
         press_active_in = 1'b0;
      end else begin
         press_active_in = press_active_ff;
      end

      long_clear = press_edge || release_edge;
      long_fire  = !stable_now_in && press_active_in
                && !(long_reported_ff && !long_clear)
                && ((|press_age[TS_W-1:CFG_W])
                    || (press_age[CFG_W-1:0] >= cfg.long_press_ms));
      long_reported_in = (long_reported_ff && !long_clear) || long_fire;

      if (press_edge) begin
         rsp.edge_code = EDGE_PRESS;
      end else if (release_edge) begin
         rsp.edge_code = EDGE_RELEASE;
      end else begin
         rsp.edge_code = NO_EDGE;
      end

      if (long_fire) begin
         rsp.press_event = EV_LONG;
      end else if (short_fire) begin
         rsp.press_event = EV_SHORT;
      end else begin
         rsp.press_event = EV_NONE;
      end

      rsp.is_down      = !stable_now_in;
      rsp.hold_time_ms = stable_now_in ? last_hold_len_in : press_age;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff         <= 1'b1;
         stable_now_ff       <= 1'b1;
         stable_before_ff    <= 1'b1;
         raw_change_stamp_ff <= '0;
         press_active_ff     <= 1'b0;
         long_reported_ff    <= 1'b0;
         press_stamp_ff      <= '0;
         last_hold_len_ff    <= '0;
      end else if (step) begin
         prev_raw_ff         <= prev_raw_in;
         stable_now_ff       <= stable_now_in;
         stable_before_ff    <= stable_before_in;
         raw_change_stamp_ff <= raw_change_stamp_in;
         press_active_ff     <= press_active_in;
         long_reported_ff    <= long_reported_in;
         press_stamp_ff      <= press_stamp_in;
         last_hold_len_ff    <= last_hold_len_in;
      end
   end

`ifndef SYNTHESIS
   a_long_while_down: assert property (@(posedge clock) disable iff (reset)
      step && rsp.press_event == EV_LONG |-> rsp.is_down)
      else $error("long event while not pressed");

   a_short_on_release: assert property (@(posedge clock) disable iff (reset)
      step && rsp.press_event == EV_SHORT |-> rsp.edge_code == EDGE_RELEASE)
      else $error("short event without release edge");

   a_long_latched: assert property (@(posedge clock) disable iff (reset)
      step && rsp.press_event == EV_LONG |=> long_reported_ff && press_active_ff)
      else $error("long event not recorded");

   a_press_zero_hold: assert property (@(posedge clock) disable iff (reset)
      step && rsp.edge_code == EDGE_PRESS |-> rsp.hold_time_ms == '0)
      else $error("nonzero hold time on press edge");
`endif

endmodule

`default_nettype wire

@@ hdl/button_debounce_short_long_press.sv @@
// path: an accepted request waits in the input register, and its response is
//   then loaded into the result register, where it is shown as valid
// throughput: one request per cycle while the response side is ready; the debounce
//   and press state is updated in the same cycle that forms the response, so back-to-back samples chain
// reset: synchronous, active high; button taken as released, timers at zero,
//   debounce 50 ms and long press 1000 ms
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// debounces an active-low button sample stream and reports stable edges,
// short and long press events, pressed state and press duration
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_short_long_press (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bdsl_req_if.sink                            req_chan,
   bdsl_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [bdsl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bdsl_pkg::CFG_W-1:0]     csr_data
);
   import bdsl_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input register stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff,  in_data_in;

   // result register stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;

   logic    req_fire;
   logic    advance;
   logic    step;
   rsp_type step_rsp;

   // result register can load when empty or being drained this cycle
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && advance;
   // input register frees up whenever its request moves on
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   // register writes, no read-back
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ms   = csr_data;
            CSR_LONG_PRESS: cfg_in.long_press_ms = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_data_in.raw_level = req_chan.raw_level;
      in_data_in.now_ms    = req_chan.now_ms;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      out_data_in = step_rsp;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= in_data_in;
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   // state update and response formation for the held request
   bdsl_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (step_rsp)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.edge_code    = out_data_ff.edge_code;
   assign rsp_chan.press_event  = out_data_ff.press_event;
   assign rsp_chan.is_down      = out_data_ff.is_down;
   assign rsp_chan.hold_time_ms = out_data_ff.hold_time_ms;

endmodule

`default_nettype wire

@@ tb/button_debounce_short_long_press_tb.sv @@
// ----------------------------------------------------------------------------
// button_debounce_short_long_press_tb
// drives pin samples with wrapping timestamps into the debouncer and checks
// every response against a cycle-free model of the debounce and gesture
// state; covers threshold extremes, wrap and backwards time, bounce trains
// and held presses around the long-press mark under random flow control
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_short_long_press_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdsl_pkg::*;

   // samples per random phase, eight phases in all
   localparam int unsigned RANDOM_PER_PHASE = 188;
   // response passes the input and result registers after acceptance, wait a little longer
   localparam int unsigned SETTLE_CYCLES    = 4;
   // generous ceiling on the whole run
   localparam int unsigned CYCLE_LIMIT      = 200000;
   // cap on printed mismatch lines
   localparam int unsigned MAX_REPORTS      = 30;

   typedef enum int unsigned {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   bdsl_req_if req_chan ();
   bdsl_rsp_if rsp_chan ();

   button_debounce_short_long_press dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // --------------------------------------------------------------------------
   // button model: configuration and state mirrored from the block
   // --------------------------------------------------------------------------
   logic [CFG_W-1:0] cfg_debounce;
   logic [CFG_W-1:0] cfg_long_press;

   logic            btn_prev_raw;     // last raw level seen
   logic            btn_stable;       // debounced level, 1 released
   logic            btn_stable_prev;  // debounced level of the step before
   logic [TS_W-1:0] btn_change_ms;    // stamp of the last raw change
   logic            btn_press_active; // press edge seen, no release yet
   logic            btn_long_sent;    // long event already given this press
   logic [TS_W-1:0] btn_press_ms;     // stamp of the press edge
   logic [TS_W-1:0] btn_last_hold;    // length of the last finished press

   // responses owed by the block, oldest first
   rsp_type button_reports[$];

   // running tallies
   int unsigned n_samples   = 0;
   int unsigned n_checked   = 0;
   int unsigned n_presses   = 0;
   int unsigned n_shorts    = 0;
   int unsigned n_longs     = 0;
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   // flow control knobs, percent per cycle
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   // timestamp the random stimulus walks forward
   logic [TS_W-1:0] sim_ms;

   // --------------------------------------------------------------------------
   // clock
   // --------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // run ceiling: a hung handshake ends the run here
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out after %0d cycles, %0d responses still owed",
                  $realtime, cycle_count, button_reports.size());
         $display("Verification failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // response side ready, random stalls by phase
   // --------------------------------------------------------------------------
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stall_pct != 0)
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         else
            rsp_chan.ready <= 1'b1;
      end
   end

   // --------------------------------------------------------------------------
   // response checker: every accepted response against the oldest owed one
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : check_reports
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (button_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with no request pending,", $realtime,
                        " got edge=%0d event=%0d", rsp_chan.edge_code,
                        rsp_chan.press_event, " down=%0d hold=%0d",
                        rsp_chan.is_down, rsp_chan.hold_time_ms);
         end else begin
            want = button_reports.pop_front();
            n_checked++;
            if (rsp_chan.edge_code    !== want.edge_code   ||
                rsp_chan.press_event  !== want.press_event ||
                rsp_chan.is_down      !== want.is_down     ||
                rsp_chan.hold_time_ms !== want.hold_time_ms) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch expected edge=%0d event=%0d", $realtime,
                           want.edge_code, want.press_event,
                           " down=%0d hold=%0d", want.is_down, want.hold_time_ms,
                           ", got edge=%0d event=%0d", rsp_chan.edge_code,
                           rsp_chan.press_event, " down=%0d hold=%0d",
                           rsp_chan.is_down, rsp_chan.hold_time_ms);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // button model
   // --------------------------------------------------------------------------
   task automatic reset_button_model();
      cfg_debounce     = DEBOUNCE_RESET;
      cfg_long_press   = LONG_PRESS_RESET;
      btn_prev_raw     = 1'b1;
      btn_stable       = 1'b1;
      btn_stable_prev  = 1'b1;
      btn_change_ms    = '0;
      btn_press_active = 1'b0;
      btn_long_sent    = 1'b0;
      btn_press_ms     = '0;
      btn_last_hold    = '0;
   endtask

   // one sample through the debounce and gesture state
   function automatic rsp_type debounce_sample(input logic raw, input logic [TS_W-1:0] now);
      rsp_type         r;
      logic [TS_W-1:0] held;
      r.edge_code   = NO_EDGE;
      r.press_event = EV_NONE;

      // restart the debounce window on any raw change
      if (raw != btn_prev_raw) begin
         btn_prev_raw  = raw;
         btn_change_ms = now;
      end
      held = now - btn_change_ms;
      if (held >= TS_W'(cfg_debounce))
         btn_stable = raw;

      // stable edges
      if (btn_stable != btn_stable_prev) begin
         if (!btn_stable) begin
            r.edge_code      = EDGE_PRESS;
            btn_press_active = 1'b1;
            btn_long_sent    = 1'b0;
            btn_press_ms     = now;
         end else begin
            r.edge_code = EDGE_RELEASE;
            if (btn_press_active) begin
               held          = now - btn_press_ms;
               btn_last_hold = held;
               if (!btn_long_sent && held < TS_W'(cfg_long_press))
                  r.press_event = EV_SHORT;
               btn_press_active = 1'b0;
               btn_long_sent    = 1'b0;
            end else begin
               btn_last_hold = '0;
            end
         end
         btn_stable_prev = btn_stable;
      end

      // long press fires once per hold, on the press step when threshold is zero
      if (!btn_stable && btn_press_active && !btn_long_sent) begin
         held = now - btn_press_ms;
         if (held >= TS_W'(cfg_long_press)) begin
            r.press_event = EV_LONG;
            btn_long_sent = 1'b1;
         end
      end

      r.is_down      = !btn_stable;
      r.hold_time_ms = !btn_stable ? now - btn_press_ms : btn_last_hold;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct    = 67;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 67;
         end
         IDLE_BOTH: begin
            sender_idle_pct    = 32;
            receiver_stall_pct = 32;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   // one pin sample request; valid stays high into the next call when no gap
   task automatic send_sample(input logic raw, input logic [TS_W-1:0] now);
      int unsigned gap;
      rsp_type     r;
      gap = 0;
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.raw_level <= raw;
      req_chan.now_ms    <= now;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      // accepted at this edge
      r = debounce_sample(raw, now);
      button_reports.push_back(r);
      n_samples++;
      if (r.edge_code == EDGE_PRESS) n_presses++;
      if (r.press_event == EV_SHORT) n_shorts++;
      if (r.press_event == EV_LONG)  n_longs++;
   endtask

   // advance the walking timestamp, then sample
   task automatic tick_sample(input logic raw, input int unsigned adv);
      sim_ms = sim_ms + TS_W'(adv);
      send_sample(raw, sim_ms);
   endtask

   // drop valid, collect every owed response, let the pipeline drain
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      while (button_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both thresholds on back-to-back edges, block idle
   task automatic configure(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] long_press);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEBOUNCE;
      csr_data         <= debounce;
      @(posedge clock);
      cfg_debounce     = debounce;
      csr_index        <= CSR_LONG_PRESS;
      csr_data         <= long_press;
      @(posedge clock);
      cfg_long_press   = long_press;
      csr_write_enable <= 1'b0;
   endtask

   // sometimes shorten a step so it lands exactly on a time mark
   function automatic int unsigned land_on(input int unsigned elapsed, input int unsigned adv,
                                           input int unsigned mark);
      if (elapsed < mark && elapsed + adv > mark && $urandom_range(1) == 1)
         return mark - elapsed;
      return adv;
   endfunction

   // well-formed press: bounce, settle, hold around the long mark, bounce, release
   task automatic play_gesture();
      int unsigned deb, lp, span, hold_mark, elapsed, adv;
      deb  = 32'(cfg_debounce);
      lp   = 32'(cfg_long_press);
      span = (deb + lp) / 4 + 1;

      // contact bounce shorter than the debounce window
      repeat ($urandom_range(0, 4)) begin
         tick_sample(1'b0, $urandom_range(0, deb / 4));
         tick_sample(1'b1, $urandom_range(0, deb / 4));
      end

      // hold length: short, exactly long, past long, just under long
      case ($urandom_range(0, 3))
         0:       hold_mark = $urandom_range(0, lp);
         1:       hold_mark = lp;
         2:       hold_mark = $urandom_range(lp, 2 * lp + 1);
         default: hold_mark = (lp == 0) ? 0 : lp - 1;
      endcase
      hold_mark += deb;

      elapsed = 0;
      tick_sample(1'b0, $urandom_range(1, span));
      while (elapsed < hold_mark) begin
         adv = $urandom_range(1, span);
         adv = land_on(elapsed, adv, deb);
         adv = land_on(elapsed, adv, hold_mark);
         elapsed += adv;
         tick_sample(1'b0, adv);
      end

      // release bounce
      repeat ($urandom_range(0, 3)) begin
         tick_sample(1'b1, $urandom_range(0, deb / 4));
         tick_sample(1'b0, $urandom_range(0, deb / 4));
      end

      // settle released
      elapsed = 0;
      tick_sample(1'b1, $urandom_range(1, span));
      while (elapsed < deb) begin
         adv = land_on(elapsed, $urandom_range(1, span), deb);
         elapsed += adv;
         tick_sample(1'b1, adv);
      end
      repeat ($urandom_range(0, 2))
         tick_sample(1'b1, $urandom_range(0, span));
   endtask

   // random levels with random steps, now and then a jump anywhere in time
   task automatic play_noise();
      int unsigned span;
      span = 32'(cfg_debounce) + 32'(cfg_long_press) + 1;
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(7) == 0) begin
            sim_ms = $urandom();
            tick_sample(1'($urandom_range(1)), 0);
         end else begin
            tick_sample(1'($urandom_range(1)), $urandom_range(0, span));
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // test tasks
   // --------------------------------------------------------------------------

   // reset thresholds 50 and 1000: bounce, press, long, release
   task automatic test_default_thresholds();
      send_sample(1'b1, 32'd0);
      send_sample(1'b0, 32'd10);    // bounce starts
      send_sample(1'b1, 32'd20);
      send_sample(1'b0, 32'd30);
      send_sample(1'b0, 32'd80);    // held 50, press edge
      send_sample(1'b0, 32'd1080);  // held 1000, long event
      send_sample(1'b1, 32'd1100);
      send_sample(1'b1, 32'd1150);  // release, no short after long
   endtask

   // debounce zero and long zero: press and long on one step, wrap on release
   task automatic test_zero_thresholds();
      configure(16'd0, 16'd0);
      send_sample(1'b0, 32'hFFFF_FFF0);
      send_sample(1'b1, 32'h0000_0005);
      send_sample(1'b1, 32'h0000_0005);
   endtask

   // widest thresholds, timestamps going backwards and across the wrap
   task automatic test_wide_thresholds();
      configure(16'hFFFF, 16'hFFFF);
      send_sample(1'b0, 32'd100);
      send_sample(1'b0, 32'd65635);       // press edge on the exact window
      send_sample(1'b0, 32'd50);          // backwards, difference wraps huge
      send_sample(1'b1, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'h0000_FFFE);   // release across the wrap
   endtask

   // immediate debounce with a short press and a long press on the mark
   task automatic test_short_press();
      configure(16'd0, 16'd30);
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd10);          // short event
      send_sample(1'b1, 32'd10);
      send_sample(1'b0, 32'd40);
      send_sample(1'b0, 32'd70);          // exactly long
      send_sample(1'b1, 32'd70);
   endtask

   // gestures and noise over eight threshold settings and four idle modes
   task automatic test_random_gestures();
      int unsigned phase_start;
      sim_ms = $urandom();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       configure(16'd0, 16'd0);
            1:       configure(16'hFFFF, 16'hFFFF);
            2:       configure(16'd0, 16'hFFFF);
            3:       configure(16'hFFFF, 16'd0);
            default: configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)));
         endcase
         set_idle_mode(idle_mode_type'(phase % 4));
         phase_start = n_samples;
         while (n_samples - phase_start < RANDOM_PER_PHASE) begin
            if ($urandom_range(4) == 0)
               play_noise();
            else
               play_gesture();
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      // every block input known from time zero
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_DEBOUNCE;
      csr_data           = '0;
      req_chan.valid     = 1'b0;
      req_chan.raw_level = 1'b1;
      req_chan.now_ms    = '0;
      sim_ms             = '0;
      reset_button_model();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part with gaps on both sides
      set_idle_mode(IDLE_BOTH);
      test_default_thresholds();
      test_zero_thresholds();
      test_wide_thresholds();
      test_short_press();

      test_random_gestures();

      settle_block();

      $display("checked %0d of %0d samples: %0d presses, %0d short and %0d long events",
               n_checked, n_samples, n_presses, n_shorts, n_longs);
      $display("thresholds swept from zero to full range, idle and stall mixes, %0d mismatches",
               mismatches);
      if (mismatches == 0 && n_checked == n_samples)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
